[src/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that cond at one edge implies result at the next edge.
`define ASSERT_NEXT(label, cond, result, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (result)) \
		else $error(msg);

`endif

[src/bchd_pkg.sv]
// Package with widths, GF(2^4) power table and syndrome helpers for the BCH(15,11) decoder.
package bchd_pkg;

	localparam int WORD_BITS = 30;
	localparam int CODE_BITS = 15;
	localparam int INFO_BITS = 11;
	localparam int PAR_BITS  = 4;
	localparam int TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;

	typedef logic [CODE_BITS-1:0] cw_t;
	typedef logic [PAR_BITS-1:0]  syn_t;
	typedef logic [WORD_BITS-1:0] word_t;

	// x^k mod (x^4 + x + 1), k = 0..14
	localparam syn_t X_POW [CODE_BITS] = '{
		4'h1, 4'h2, 4'h4, 4'h8, 4'h3, 4'h6, 4'hC, 4'hB,
		4'h5, 4'hA, 4'h7, 4'hE, 4'hF, 4'hD, 4'h9
	};

	// Codeword bit c is the coefficient of x^(14-c); bit 0 is sent first.
	function automatic syn_t bch_syndrome(input cw_t cw);
		syn_t s;
		s = '0;
		for (int c = 0; c < CODE_BITS; c++) begin
			if (cw[c])
				s ^= X_POW[CODE_BITS-1-c];
		end
		return s;
	endfunction

	// One-hot flip mask for a nonzero syndrome, zero otherwise.
	function automatic cw_t bch_err_mask(input syn_t syn);
		cw_t m;
		m = '0;
		for (int c = 0; c < CODE_BITS; c++)
			m[c] = (syn != '0) && (syn == X_POW[CODE_BITS-1-c]);
		return m;
	endfunction

endpackage

[src/bch_15_11_word_decoder.sv]
// Top level: three-stage BCH(15,11) single-error-correcting word decoder.
// Throughput: one word per cycle while m_tready is high; each stage holds only when the
// stage after it is full; a word passes the stage 1, 2 and 3 registers on its way out.
// Stage 1 deinterleaves and forms both syndromes, stage 2 turns each syndrome into a flip
// mask, stage 3 corrects and packs.
// Reset (arst_n low, asynchronous) empties all stages; data registers are not cleared.
`include "assert_macros.svh"

module bch_15_11_word_decoder
	import bchd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_BITS-1:0] s_tdata,  // [29:0] symbol_signs, [31:30] zero
	input  logic [0:0]            s_tuser,  // [0] first_word
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_BITS-1:0] m_tdata   // [29:0] decoded_word, [31:30] zero
);

	// Stage valid bits and per-stage ready (a stage takes new data when empty
	// or when its content moves on in the same cycle).
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	// Stage 1: deinterleaved codewords plus their syndromes
	cw_t  cw_a_s1, cw_b_s1;
	syn_t syn_a_s1, syn_b_s1;
	logic first_s1;

	// Stage 2: codewords plus their one-hot flip masks
	cw_t  cw_a_s2, cw_b_s2;
	cw_t  err_a_s2, err_b_s2;
	logic first_s2;

	// Stage 3: packed result word
	word_t word_s3;

	cw_t   in_a, in_b;
	cw_t   fix_a, fix_b;
	word_t packed_word, raw_word;

	assign rdy_s3   = !v_s3 || m_tready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// Split even symbols into codeword A, odd symbols into codeword B.
	always_comb begin
		for (int c = 0; c < CODE_BITS; c++) begin
			in_a[c] = s_tdata[2*c];
			in_b[c] = s_tdata[2*c+1];
		end
	end

	// Flip the bit each mask points at; rebuild the raw word for pass-through.
	always_comb begin
		fix_a = cw_a_s2 ^ err_a_s2;
		fix_b = cw_b_s2 ^ err_b_s2;
		packed_word = {fix_b[CODE_BITS-1:INFO_BITS], fix_a[CODE_BITS-1:INFO_BITS],
			fix_b[INFO_BITS-1:0], fix_a[INFO_BITS-1:0]};
		for (int c = 0; c < CODE_BITS; c++) begin
			raw_word[2*c]   = cw_a_s2[c];
			raw_word[2*c+1] = cw_b_s2[c];
		end
	end

	// Valid bits: advance when the next stage can take the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= s_tvalid;
			if (rdy_s2)
				v_s2 <= v_s1;
			if (rdy_s3)
				v_s3 <= v_s2;
		end
	end

	// Payload registers: load on the same enables, hold otherwise.
	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			cw_a_s1  <= in_a;
			cw_b_s1  <= in_b;
			syn_a_s1 <= bch_syndrome(in_a);
			syn_b_s1 <= bch_syndrome(in_b);
			first_s1 <= s_tuser[0];
		end
		if (rdy_s2 && v_s1) begin
			cw_a_s2  <= cw_a_s1;
			cw_b_s2  <= cw_b_s1;
			err_a_s2 <= bch_err_mask(syn_a_s1);
			err_b_s2 <= bch_err_mask(syn_b_s1);
			first_s2 <= first_s1;
		end
		if (rdy_s3 && v_s2)
			word_s3 <= first_s2 ? raw_word : packed_word;
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {{(TDATA_BITS-WORD_BITS){1'b0}}, word_s3};

	// Input may stall only when every stage is full.
	`ASSERT_CLK(a_stall_full, !s_tready |-> (v_s1 && v_s2 && v_s3),
		"input stalled with a bubble")
	// A blocked stage 1 keeps its codewords.
	`ASSERT_NEXT(a_s1_hold, v_s1 && !rdy_s2,
		v_s1 && $stable(cw_a_s1) && $stable(cw_b_s1), "stage 1 lost data on stall")
	// Zero syndrome on A leaves A info bits untouched.
	`ASSERT_NEXT(a_clean_a, v_s2 && rdy_s3 && !first_s2 && err_a_s2 == '0,
		word_s3[INFO_BITS-1:0] == $past(cw_a_s2[INFO_BITS-1:0]), "clean codeword A altered")
	// A valid result stays valid until its transaction completes.
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

endmodule

[tb/bch_15_11_word_decoder_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the BCH(15,11) word decoder stream block.
module bch_15_11_word_decoder_tb
	import bchd_pkg::*;
();

	localparam int MAX_GAP      = 18;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 12;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [TDATA_BITS-1:0] s_tdata = '0;  // [29:0] symbol_signs, [31:30] zero
	logic [0:0]            s_tuser = '0;  // [0] first_word
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_BITS-1:0] m_tdata;       // [29:0] decoded_word, [31:30] zero

	word_t pending_words[$];
	int    error_count = 0;
	int    stall_cycles = 0;
	int    rx_wait = 0;
	int    rx_hold = 0;
	bit    hold_request = 1'b0;
	bit    tx_no_idle = 1'b0;
	bit    rx_no_idle = 1'b0;

	bch_15_11_word_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Remainder of the codeword polynomial mod x^4 + x + 1; bit 0 shifts in first.
	function automatic logic [3:0] gf_remainder(input cw_t cw);
		logic [3:0] r;
		logic       fb;
		r = '0;
		for (int c = 0; c < CODE_BITS; c++) begin
			fb = r[3];
			r = {r[2:0], cw[c] ^ fb};
			if (fb)
				r[1] = ~r[1];
		end
		return r;
	endfunction

	// Invert the one bit whose single-error remainder matches the syndrome.
	function automatic cw_t correct_codeword(input cw_t cw);
		logic [3:0] s;
		s = gf_remainder(cw);
		if (s != '0) begin
			for (int c = 0; c < CODE_BITS; c++) begin
				if (gf_remainder(cw_t'(1) << c) == s)
					cw[c] = ~cw[c];
			end
		end
		return cw;
	endfunction

	// Expected decoded word: pass the first word, else split, correct and repack.
	function automatic word_t expected_word(input word_t sym, input bit first);
		cw_t a;
		cw_t b;
		if (first)
			return sym;
		for (int c = 0; c < CODE_BITS; c++) begin
			a[c] = sym[2*c];
			b[c] = sym[2*c+1];
		end
		a = correct_codeword(a);
		b = correct_codeword(b);
		return {b[14:11], a[14:11], b[10:0], a[10:0]};
	endfunction

	// Systematic codeword: info in bits 0..10, remainder in bits 11..14.
	function automatic cw_t encode_info(input logic [10:0] info);
		cw_t        cw;
		logic [3:0] r;
		cw = '0;
		cw[10:0] = info;
		r = gf_remainder(cw);
		for (int k = 0; k < PAR_BITS; k++)
			cw[CODE_BITS-1-k] = r[k];
		return cw;
	endfunction

	function automatic word_t interleave(input cw_t a, input cw_t b);
		word_t w;
		for (int c = 0; c < CODE_BITS; c++) begin
			w[2*c]   = a[c];
			w[2*c+1] = b[c];
		end
		return w;
	endfunction

	function automatic cw_t add_errors(input cw_t cw);
		int n;
		int roll;
		roll = $urandom_range(9, 0);
		n = (roll < 4) ? 0 : ((roll < 8) ? 1 : 2);
		for (int i = 0; i < n; i++)
			cw[$urandom_range(CODE_BITS-1, 0)] ^= 1'b1;
		return cw;
	endfunction

	// Valid codeword pair with up to two flips per half, either polarity.
	function automatic word_t noisy_word();
		word_t w;
		w = interleave(add_errors(encode_info(11'($urandom))),
			add_errors(encode_info(11'($urandom))));
		if ($urandom_range(1, 0))
			w = ~w;
		return w;
	endfunction

	function automatic int draw_gap(input bit no_idle);
		return no_idle ? 0 : $urandom_range(MAX_GAP, 0);
	endfunction

	// Offer one word after a random gap; hold it until the transaction completes.
	task automatic send_word(input word_t sym, input bit first);
		int gap;
		gap = draw_gap(tx_no_idle);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(TDATA_BITS-WORD_BITS){1'b0}}, sym};
		s_tuser  <= first;
		pending_words.insert(pending_words.size(), expected_word(sym, first));
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Extremes, every nonzero syndrome in both halves, double errors, first words.
	task automatic test_directed();
		cw_t a;
		cw_t b;
		send_word('0, 1'b1);
		send_word('1, 1'b1);
		send_word('0, 1'b0);
		send_word('1, 1'b0);
		for (int c = 0; c < CODE_BITS; c++) begin
			a = encode_info(11'h5A3);
			b = encode_info(11'h2C7);
			a[c] ^= 1'b1;
			b[CODE_BITS-1-c] ^= 1'b1;
			send_word(interleave(a, b), 1'b0);
		end
		a = encode_info(11'h7FF);
		a[0] ^= 1'b1;
		a[7] ^= 1'b1;
		b = encode_info(11'h001);
		b[3] ^= 1'b1;
		b[14] ^= 1'b1;
		send_word(interleave(a, b), 1'b0);
		a = encode_info(11'h3C5);
		a[12] ^= 1'b1;
		send_word(~interleave(a, encode_info(11'h4B9)), 1'b0);
		send_word(word_t'($urandom), 1'b1);
	endtask

	// Mostly well-formed words, some raw noise and some first words.
	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9, 0) == 0)
				send_word(word_t'($urandom), 1'b1);
			else if ($urandom_range(3, 0) != 0)
				send_word(noisy_word(), 1'b0);
			else
				send_word(word_t'($urandom), 1'b0);
		end
	endtask

	task automatic test_back_to_back();
		tx_no_idle = 1'b1;
		rx_no_idle = 1'b1;
		test_random_traffic(100);
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
	endtask

	// Hold the output off for a long stretch while words keep coming.
	task automatic test_output_backpressure();
		tx_no_idle = 1'b1;
		hold_request = 1'b1;
		test_random_traffic(60);
		tx_no_idle = 1'b0;
	endtask

	// Check each result transaction; then choose the next ready level.
	always @(posedge clk) begin
		word_t want;
		if (m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				$error("result with no word pending: %h", m_tdata);
				error_count++;
			end else begin
				want = pending_words.pop_front();
				if (m_tdata[WORD_BITS-1:0] !== want) begin
					$error("decoded_word expected %h actual %h", want,
						m_tdata[WORD_BITS-1:0]);
					error_count++;
				end
				if (m_tdata[TDATA_BITS-1:WORD_BITS] !== '0) begin
					$error("tdata padding expected %h actual %h", 2'b00,
						m_tdata[TDATA_BITS-1:WORD_BITS]);
					error_count++;
				end
			end
			rx_wait = draw_gap(rx_no_idle);
		end
		if (hold_request) begin
			hold_request = 1'b0;
			rx_hold = HOLD_CYCLES;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Abort when no transaction on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(250);
		test_back_to_back();
		test_output_backpressure();
		test_random_traffic(120);
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/bchd_pkg.sv
src/bch_15_11_word_decoder.sv
tb/bch_15_11_word_decoder_tb.sv
